### rtl/mhpq_pkg.sv
package mhpq_pkg;

	localparam int CAPACITY = 1024;
	localparam int DATA_W   = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int PTR_W    = CNT_W + 1;
	localparam int STAT_W   = 2;
	localparam int UPC_W    = 4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// sequencer jumps
	localparam logic [3:0] J_NEXT     = 4'd0;
	localparam logic [3:0] J_GOTO     = 4'd1;
	localparam logic [3:0] J_DISPATCH = 4'd2;
	localparam logic [3:0] J_IF_FULL  = 4'd3;
	localparam logic [3:0] J_IF_EMPTY = 4'd4;
	localparam logic [3:0] J_IF_ROOT  = 4'd5;
	localparam logic [3:0] J_IF_NOL   = 4'd6;
	localparam logic [3:0] J_IF_SWAP  = 4'd7;
	localparam logic [3:0] J_EMIT     = 4'd8;

	// read address select
	localparam logic [1:0] RA_PARENT = 2'd0;
	localparam logic [1:0] RA_LAST   = 2'd1;
	localparam logic [1:0] RA_LEFT   = 2'd2;
	localparam logic [1:0] RA_RIGHT  = 2'd3;

	// memory write
	localparam logic [1:0] WR_NONE = 2'd0;
	localparam logic [1:0] WR_MV   = 2'd1;
	localparam logic [1:0] WR_SWAP = 2'd2;

	// position update
	localparam logic [1:0] POS_HOLD = 2'd0;
	localparam logic [1:0] POS_ONE  = 2'd1;
	localparam logic [1:0] POS_CNT1 = 2'd2;
	localparam logic [1:0] POS_SWAP = 2'd3;

	// count update
	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_INC  = 2'd1;
	localparam logic [1:0] CNT_DEC  = 2'd2;

	// register loads
	localparam logic [1:0] LD_NONE  = 2'd0;
	localparam logic [1:0] LD_MV_RD = 2'd1;
	localparam logic [1:0] LD_OTH   = 2'd2;

	// status update
	localparam logic [1:0] SU_KEEP  = 2'd0;
	localparam logic [1:0] SU_FULL  = 2'd1;
	localparam logic [1:0] SU_EMPTY = 2'd2;

	localparam logic DIR_UP   = 1'b0;
	localparam logic DIR_DOWN = 1'b1;

	// microprogram addresses
	localparam logic [UPC_W-1:0] U_IDLE    = 4'd0;
	localparam logic [UPC_W-1:0] U_INS     = 4'd1;
	localparam logic [UPC_W-1:0] U_INS_CNT = 4'd2;
	localparam logic [UPC_W-1:0] U_UP      = 4'd3;
	localparam logic [UPC_W-1:0] U_UP_CMP  = 4'd4;
	localparam logic [UPC_W-1:0] U_UP_PUT  = 4'd5;
	localparam logic [UPC_W-1:0] U_FULL    = 4'd6;
	localparam logic [UPC_W-1:0] U_REM     = 4'd7;
	localparam logic [UPC_W-1:0] U_REM_LD  = 4'd8;
	localparam logic [UPC_W-1:0] U_DN      = 4'd9;
	localparam logic [UPC_W-1:0] U_DN_RT   = 4'd10;
	localparam logic [UPC_W-1:0] U_DN_CMP  = 4'd11;
	localparam logic [UPC_W-1:0] U_DN_PUT  = 4'd12;
	localparam logic [UPC_W-1:0] U_EMPTY   = 4'd13;
	localparam logic [UPC_W-1:0] U_EMIT    = 4'd14;

	typedef struct packed {
		logic [3:0]       jmp;
		logic [UPC_W-1:0] tgt;
		logic [1:0]       ra;
		logic [1:0]       wr;
		logic [1:0]       pos;
		logic [1:0]       cnt;
		logic [1:0]       ld;
		logic [1:0]       su;
		logic             dir;
	} ctl_t;

	typedef struct packed {
		logic in_fire;
		logic in_remove;
		logic full;
		logic empty;
		logic root;
		logic nol;
		logic swap;
		logic out_free;
	} flags_t;

	function automatic ctl_t ucode_rom(input logic [UPC_W-1:0] upc);
		ctl_t cw;
		cw = '0;
		unique case (upc)
			U_IDLE: begin
				cw.jmp = J_DISPATCH;
				cw.tgt = U_REM;
			end
			U_INS: begin
				cw.jmp = J_IF_FULL;
				cw.tgt = U_FULL;
			end
			U_INS_CNT: begin
				cw.cnt = CNT_INC;
				cw.pos = POS_CNT1;
			end
			U_UP: begin
				cw.ra  = RA_PARENT;
				cw.jmp = J_IF_ROOT;
				cw.tgt = U_UP_PUT;
			end
			U_UP_CMP: begin
				cw.dir = DIR_UP;
				cw.wr  = WR_SWAP;
				cw.pos = POS_SWAP;
				cw.jmp = J_IF_SWAP;
				cw.tgt = U_UP;
			end
			U_UP_PUT: begin
				cw.wr  = WR_MV;
				cw.jmp = J_GOTO;
				cw.tgt = U_EMIT;
			end
			U_FULL: begin
				cw.su  = SU_FULL;
				cw.jmp = J_GOTO;
				cw.tgt = U_EMIT;
			end
			U_REM: begin
				cw.ra  = RA_LAST;
				cw.jmp = J_IF_EMPTY;
				cw.tgt = U_EMPTY;
			end
			U_REM_LD: begin
				cw.ld  = LD_MV_RD;
				cw.cnt = CNT_DEC;
				cw.pos = POS_ONE;
			end
			U_DN: begin
				cw.ra  = RA_LEFT;
				cw.jmp = J_IF_NOL;
				cw.tgt = U_DN_PUT;
			end
			U_DN_RT: begin
				cw.ld = LD_OTH;
				cw.ra = RA_RIGHT;
			end
			U_DN_CMP: begin
				cw.dir = DIR_DOWN;
				cw.wr  = WR_SWAP;
				cw.pos = POS_SWAP;
				cw.jmp = J_IF_SWAP;
				cw.tgt = U_DN;
			end
			U_DN_PUT: begin
				cw.wr  = WR_MV;
				cw.jmp = J_GOTO;
				cw.tgt = U_EMIT;
			end
			U_EMPTY: begin
				cw.su  = SU_EMPTY;
				cw.jmp = J_GOTO;
				cw.tgt = U_EMIT;
			end
			U_EMIT: begin
				cw.jmp = J_EMIT;
				cw.tgt = U_IDLE;
			end
			default: begin
				cw.jmp = J_GOTO;
				cw.tgt = U_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

### rtl/max_heap_priority_queue_core.sv
// max-heap priority queue of up to 1024 signed 32-bit values
//
// input channel (in_valid/in_ready): kind 0 inserts value, kind 1 removes the
// maximum. output channel (out_valid/out_ready): one result per item with the
// top value after the operation (zero when empty), the count, an empty flag
// and a status (ok, insert refused when full, remove refused when empty).
//
// items are handled one at a time by a microcoded sequencer over a
// single-port-read heap memory with registered read. insert climbs and
// remove descends the heap one level at a time, each level waiting on a
// memory read. in_ready is high only while the sequencer waits for an item.
//
// the result sits in an output register: the next item is accepted while it
// waits, and the sequencer holds in its final step until that register is
// free. reset empties the heap at once; memory contents are not cleared.
module max_heap_priority_queue_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 kind,
	input  logic signed [mhpq_pkg::DATA_W-1:0]   value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [mhpq_pkg::DATA_W-1:0]   top_value,
	output logic        [mhpq_pkg::CNT_W-1:0]    count,
	output logic                                 empty_res,
	output logic        [mhpq_pkg::STAT_W-1:0]   status
);
	import mhpq_pkg::*;

	ctl_t   cw;
	flags_t flags;

	logic        [CNT_W-1:0]  cnt_q;
	logic        [CNT_W-1:0]  pos_q;
	logic signed [DATA_W-1:0] mv_q;
	logic signed [DATA_W-1:0] oth_q;
	logic signed [DATA_W-1:0] root_q;
	logic        [STAT_W-1:0] st_q;

	logic signed [DATA_W-1:0] rd_data;
	logic signed [DATA_W-1:0] cand;
	logic signed [DATA_W-1:0] wdata;
	logic        [PTR_W-1:0]  lchild;
	logic        [PTR_W-1:0]  rchild;
	logic        [PTR_W-1:0]  rslot;
	logic        [PTR_W-1:0]  rslot_m1;
	logic        [CNT_W-1:0]  wslot_m1;
	logic        [ADDR_W-1:0] raddr;
	logic        [ADDR_W-1:0] waddr;
	logic        [CNT_W-1:0]  down_pos;
	logic                     pick_r;
	logic                     swap;
	logic                     we;
	logic                     in_fire;
	logic                     emit_go;

	mhpq_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.cw     (cw)
	);

	assign in_ready = (cw.jmp == J_DISPATCH);
	assign in_fire  = in_valid && in_ready;
	assign emit_go  = (cw.jmp == J_EMIT) && (!out_valid || out_ready);

	assign lchild = {pos_q, 1'b0};
	assign rchild = {pos_q, 1'b1};

	// left wins a tie, a missing right child never wins
	assign pick_r = (rchild <= {1'b0, cnt_q}) && (rd_data > oth_q);
	assign cand   = (cw.dir == DIR_UP) ? rd_data : (pick_r ? rd_data : oth_q);
	assign swap   = (cw.dir == DIR_UP) ? (mv_q > cand) : (cand > mv_q);
	assign down_pos = {pos_q[CNT_W-2:0], pick_r};

	assign flags.in_fire   = in_fire;
	assign flags.in_remove = kind;
	assign flags.full      = (cnt_q == CNT_W'(CAPACITY));
	assign flags.empty     = (cnt_q == '0);
	assign flags.root      = (pos_q == CNT_W'(1));
	assign flags.nol       = (lchild > {1'b0, cnt_q});
	assign flags.swap      = swap;
	assign flags.out_free  = !out_valid || out_ready;

	always_comb begin
		unique case (cw.ra)
			RA_PARENT: rslot = {2'b00, pos_q[CNT_W-1:1]};
			RA_LAST:   rslot = {1'b0, cnt_q};
			RA_LEFT:   rslot = lchild;
			RA_RIGHT:  rslot = rchild;
			default:   rslot = lchild;
		endcase
	end

	// slot s lives at address s-1
	assign rslot_m1 = rslot - PTR_W'(1);
	assign raddr    = rslot_m1[ADDR_W-1:0];
	assign wslot_m1 = pos_q - CNT_W'(1);
	assign waddr    = wslot_m1[ADDR_W-1:0];

	assign we    = (cw.wr == WR_MV) || ((cw.wr == WR_SWAP) && swap);
	assign wdata = (cw.wr == WR_MV) ? mv_q : cand;

	mhpq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_heap_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			unique case (cw.cnt)
				CNT_INC: cnt_q <= cnt_q + CNT_W'(1);
				CNT_DEC: cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
			if (emit_go) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mv_q <= value;
			st_q <= ST_OK;
		end else if (cw.ld == LD_MV_RD) begin
			mv_q <= rd_data;
		end
		if (cw.ld == LD_OTH) begin
			oth_q <= rd_data;
		end
		if (cw.su == SU_FULL) begin
			st_q <= ST_FULL;
		end else if (cw.su == SU_EMPTY) begin
			st_q <= ST_EMPTY;
		end
		unique case (cw.pos)
			POS_ONE:  pos_q <= CNT_W'(1);
			POS_CNT1: pos_q <= cnt_q + CNT_W'(1);
			POS_SWAP: begin
				if (swap) begin
					pos_q <= (cw.dir == DIR_UP) ? (pos_q >> 1) : down_pos;
				end
			end
			default:  pos_q <= pos_q;
		endcase
		// mirror of slot one for the top value
		if (we && (pos_q == CNT_W'(1))) begin
			root_q <= wdata;
		end
		if (emit_go) begin
			top_value <= (cnt_q == '0) ? '0 : root_q;
			count     <= cnt_q;
			empty_res <= (cnt_q == '0);
			status    <= st_q;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.cnt != CNT_HOLD) |=> (cnt_q != $past(cnt_q)))
		else $error("count update lost");

	// removing the last item still parks the moved value in slot one
	a_wr_slot: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (pos_q != '0) && ((pos_q <= cnt_q) || (cnt_q == '0)))
		else $error("heap write outside stored slots");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !we && !emit_go)
		else $error("sequencer active while waiting for an item");

endmodule

### rtl/mhpq_ram.sv
module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/mhpq_useq.sv
module mhpq_useq (
	input  logic            clk,
	input  logic            arst_n,
	input  mhpq_pkg::flags_t flags,
	output mhpq_pkg::ctl_t   cw
);
	import mhpq_pkg::*;

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_nxt;
	logic [UPC_W-1:0] upc_inc;

	assign cw      = ucode_rom(upc_q);
	assign upc_inc = upc_q + UPC_W'(1);

	always_comb begin
		unique case (cw.jmp)
			J_NEXT:     upc_nxt = upc_inc;
			J_GOTO:     upc_nxt = cw.tgt;
			J_DISPATCH: upc_nxt = !flags.in_fire ? upc_q :
			                      (flags.in_remove ? cw.tgt : upc_inc);
			J_IF_FULL:  upc_nxt = flags.full  ? cw.tgt : upc_inc;
			J_IF_EMPTY: upc_nxt = flags.empty ? cw.tgt : upc_inc;
			J_IF_ROOT:  upc_nxt = flags.root  ? cw.tgt : upc_inc;
			J_IF_NOL:   upc_nxt = flags.nol   ? cw.tgt : upc_inc;
			J_IF_SWAP:  upc_nxt = flags.swap  ? cw.tgt : upc_inc;
			J_EMIT:     upc_nxt = flags.out_free ? cw.tgt : upc_q;
			default:    upc_nxt = U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

### test/mhpq_tb_pkg.sv
`timescale 1ns / 1ps

package mhpq_tb_pkg;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} heap_op_e;

endpackage

### test/heap_result_checker.sv
`timescale 1ns / 1ps

module heap_result_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic                               kind,
	input  logic signed [mhpq_pkg::DATA_W-1:0] value,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [mhpq_pkg::DATA_W-1:0] top_value,
	input  logic        [mhpq_pkg::CNT_W-1:0]  count,
	input  logic                               empty_res,
	input  logic        [mhpq_pkg::STAT_W-1:0] status,
	output int                                 fail_cnt,
	output int                                 pending
);
	import mhpq_pkg::*;
	import mhpq_tb_pkg::*;

	typedef struct packed {
		logic signed [DATA_W-1:0] top;
		logic        [CNT_W-1:0]  cnt;
		logic                     empty;
		logic        [STAT_W-1:0] stat;
	} heap_result_t;

	// own copy of the heap, one-based
	logic signed [DATA_W-1:0] slots [1:CAPACITY];
	int                       used;
	int                       fails;
	heap_result_t             expected_results [$];

	initial begin
		fail_cnt = 0;
		pending  = 0;
		fails    = 0;
		used     = 0;
	end

	task automatic swap_slots(input int a, input int b);
		logic signed [DATA_W-1:0] t;
		t        = slots[a];
		slots[a] = slots[b];
		slots[b] = t;
	endtask

	task automatic apply_heap_op(input heap_op_e op, input logic signed [DATA_W-1:0] v,
		output heap_result_t r);
		int pos;
		int l;
		int pick;
		r.stat = ST_OK;
		if (op == OP_INSERT) begin
			if (used >= CAPACITY) begin
				r.stat = ST_FULL;
			end else begin
				used++;
				slots[used] = v;
				pos = used;
				while (pos > 1 && slots[pos] > slots[pos / 2]) begin
					swap_slots(pos, pos / 2);
					pos = pos / 2;
				end
			end
		end else if (used == 0) begin
			r.stat = ST_EMPTY;
		end else begin
			slots[1] = slots[used];
			used--;
			pos = 1;
			while (1) begin
				l = 2 * pos;
				if (l > used)
					break;
				pick = l;
				// left child wins a tie
				if (l + 1 <= used && slots[l + 1] > slots[l])
					pick = l + 1;
				if (!(slots[pick] > slots[pos]))
					break;
				swap_slots(pick, pos);
				pos = pick;
			end
		end
		r.top   = (used > 0) ? slots[1] : '0;
		r.cnt   = CNT_W'(used);
		r.empty = (used == 0);
	endtask

	task automatic report_field(input string field, input longint want, input longint got);
		$display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		heap_result_t want;
		heap_result_t fresh;
		if (!arst_n) begin
			used = 0;
			expected_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with no item waiting: expected none, got top %0d count %0d",
						$time, top_value, count);
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (top_value !== want.top)
						report_field("top_value", want.top, top_value);
					if (count !== want.cnt)
						report_field("count", want.cnt, count);
					if (empty_res !== want.empty)
						report_field("empty_res", want.empty, empty_res);
					if (status !== want.stat)
						report_field("status", want.stat, status);
				end
			end
			if (in_valid && in_ready) begin
				apply_heap_op(heap_op_e'(kind), value, fresh);
				expected_results.push_back(fresh);
			end
		end
		fail_cnt <= fails;
		pending  <= expected_results.size();
	end

endmodule

### test/tb_max_heap_priority_queue_core.sv
`timescale 1ns / 1ps

module tb_max_heap_priority_queue_core;
	import mhpq_pkg::*;
	import mhpq_tb_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic                     kind      = OP_INSERT;
	logic signed [DATA_W-1:0] value     = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] top_value;
	logic        [CNT_W-1:0]  count;
	logic                     empty_res;
	logic        [STAT_W-1:0] status;

	int   fail_cnt;
	int   pending;
	int   occupancy  = 0;
	int   cycles     = 0;
	int   stall_left = 0;
	logic gaps_on    = 1'b0;
	logic stalls_on  = 1'b0;

	max_heap_priority_queue_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.top_value (top_value),
		.count     (count),
		.empty_res (empty_res),
		.status    (status)
	);

	heap_result_checker result_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.top_value (top_value),
		.count     (count),
		.empty_res (empty_res),
		.status    (status),
		.fail_cnt  (fail_cnt),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left > 1) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (stall_left == 1) begin
			stall_left = 0;
			out_ready <= 1'b1;
		end else if (stalls_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 5);
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n;
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0, 1: return $signed($urandom_range(0, 6)) - 3;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return '0;
					default: return -1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input heap_op_e op, input logic signed [DATA_W-1:0] v);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= op;
		value    <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (op == OP_INSERT && occupancy < CAPACITY)
			occupancy++;
		else if (op == OP_REMOVE && occupancy > 0)
			occupancy--;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_random(input int n, input int insert_pct);
		heap_op_e op;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
			send_item(op, pick_value());
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n    <= 1'b1;
		gaps_on   <= 1'b1;
		stalls_on <= 1'b1;
		@(posedge clk);

		// remove from empty, extremes, equal values
		send_item(OP_REMOVE, 32'sd5);
		send_item(OP_INSERT, '0);
		send_item(OP_INSERT, 32'sh7fffffff);
		send_item(OP_INSERT, 32'sh80000000);
		send_item(OP_INSERT, -1);
		send_item(OP_INSERT, 32'sd7);
		send_item(OP_INSERT, 32'sd7);
		// draining six passes through a root with a lone left child
		repeat (6) send_item(OP_REMOVE, $urandom);
		send_item(OP_REMOVE, $urandom);
		// equal children under the root
		send_item(OP_INSERT, 32'sd9);
		send_item(OP_INSERT, 32'sd4);
		send_item(OP_INSERT, 32'sd4);
		send_item(OP_INSERT, 32'sd1);
		repeat (4) send_item(OP_REMOVE, $urandom);

		drain_results();

		for (int chunk = 0; chunk < 8; chunk++) begin
			gaps_on   <= (chunk % 3 != 2);
			stalls_on <= (chunk % 4 != 3);
			send_random(40, (chunk < 4) ? 65 : 45);
			if (chunk == 3)
				drain_results();
		end

		// drain to empty, then refused removes
		gaps_on   <= 1'b1;
		stalls_on <= 1'b1;
		while (occupancy > 0)
			send_item(OP_REMOVE, $urandom);
		send_item(OP_REMOVE, $urandom);
		send_item(OP_REMOVE, $urandom);

		gaps_on   <= 1'b0;
		stalls_on <= 1'b0;
		send_random(60, 60);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		if (fail_cnt == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
